/* src/sha512_pkg.sv */
// Shared constants, types and round functions for the SHA-512 engine.
package sha512_pkg;

    localparam int unsigned WORD_W = 64;

    typedef logic [63:0] word_t;

    localparam word_t INIT_H0 = 64'h6a09e667f3bcc908;
    localparam word_t INIT_H1 = 64'hbb67ae8584caa73b;
    localparam word_t INIT_H2 = 64'h3c6ef372fe94f82b;
    localparam word_t INIT_H3 = 64'ha54ff53a5f1d36f1;
    localparam word_t INIT_H4 = 64'h510e527fade682d1;
    localparam word_t INIT_H5 = 64'h9b05688c2b3e6c1f;
    localparam word_t INIT_H6 = 64'h1f83d9abfb41bd6b;
    localparam word_t INIT_H7 = 64'h5be0cd19137e2179;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Commands from the sequencer to the round datapath.
    typedef struct packed {
        logic load;      // copy chaining words into working registers
        logic round_en;  // run one round
        logic fold;      // add working registers into chaining words
        logic reinit;    // restore the initial hash
    } rnd_ctrl_t;

    function automatic word_t rotr(input word_t x, input int unsigned n);
        rotr = (x >> n) | (x << (64 - n));
    endfunction

    function automatic word_t sig0(input word_t x);
        sig0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
    endfunction

    function automatic word_t sig1(input word_t x);
        sig1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
    endfunction

    function automatic word_t round_k(input logic [6:0] i);
        case (i)
            7'd0: round_k = 64'h428a2f98d728ae22;  7'd1: round_k = 64'h7137449123ef65cd;
            7'd2: round_k = 64'hb5c0fbcfec4d3b2f;  7'd3: round_k = 64'he9b5dba58189dbbc;
            7'd4: round_k = 64'h3956c25bf348b538;  7'd5: round_k = 64'h59f111f1b605d019;
            7'd6: round_k = 64'h923f82a4af194f9b;  7'd7: round_k = 64'hab1c5ed5da6d8118;
            7'd8: round_k = 64'hd807aa98a3030242;  7'd9: round_k = 64'h12835b0145706fbe;
            7'd10: round_k = 64'h243185be4ee4b28c; 7'd11: round_k = 64'h550c7dc3d5ffb4e2;
            7'd12: round_k = 64'h72be5d74f27b896f; 7'd13: round_k = 64'h80deb1fe3b1696b1;
            7'd14: round_k = 64'h9bdc06a725c71235; 7'd15: round_k = 64'hc19bf174cf692694;
            7'd16: round_k = 64'he49b69c19ef14ad2; 7'd17: round_k = 64'hefbe4786384f25e3;
            7'd18: round_k = 64'h0fc19dc68b8cd5b5; 7'd19: round_k = 64'h240ca1cc77ac9c65;
            7'd20: round_k = 64'h2de92c6f592b0275; 7'd21: round_k = 64'h4a7484aa6ea6e483;
            7'd22: round_k = 64'h5cb0a9dcbd41fbd4; 7'd23: round_k = 64'h76f988da831153b5;
            7'd24: round_k = 64'h983e5152ee66dfab; 7'd25: round_k = 64'ha831c66d2db43210;
            7'd26: round_k = 64'hb00327c898fb213f; 7'd27: round_k = 64'hbf597fc7beef0ee4;
            7'd28: round_k = 64'hc6e00bf33da88fc2; 7'd29: round_k = 64'hd5a79147930aa725;
            7'd30: round_k = 64'h06ca6351e003826f; 7'd31: round_k = 64'h142929670a0e6e70;
            7'd32: round_k = 64'h27b70a8546d22ffc; 7'd33: round_k = 64'h2e1b21385c26c926;
            7'd34: round_k = 64'h4d2c6dfc5ac42aed; 7'd35: round_k = 64'h53380d139d95b3df;
            7'd36: round_k = 64'h650a73548baf63de; 7'd37: round_k = 64'h766a0abb3c77b2a8;
            7'd38: round_k = 64'h81c2c92e47edaee6; 7'd39: round_k = 64'h92722c851482353b;
            7'd40: round_k = 64'ha2bfe8a14cf10364; 7'd41: round_k = 64'ha81a664bbc423001;
            7'd42: round_k = 64'hc24b8b70d0f89791; 7'd43: round_k = 64'hc76c51a30654be30;
            7'd44: round_k = 64'hd192e819d6ef5218; 7'd45: round_k = 64'hd69906245565a910;
            7'd46: round_k = 64'hf40e35855771202a; 7'd47: round_k = 64'h106aa07032bbd1b8;
            7'd48: round_k = 64'h19a4c116b8d2d0c8; 7'd49: round_k = 64'h1e376c085141ab53;
            7'd50: round_k = 64'h2748774cdf8eeb99; 7'd51: round_k = 64'h34b0bcb5e19b48a8;
            7'd52: round_k = 64'h391c0cb3c5c95a63; 7'd53: round_k = 64'h4ed8aa4ae3418acb;
            7'd54: round_k = 64'h5b9cca4f7763e373; 7'd55: round_k = 64'h682e6ff3d6b2b8a3;
            7'd56: round_k = 64'h748f82ee5defb2fc; 7'd57: round_k = 64'h78a5636f43172f60;
            7'd58: round_k = 64'h84c87814a1f0ab72; 7'd59: round_k = 64'h8cc702081a6439ec;
            7'd60: round_k = 64'h90befffa23631e28; 7'd61: round_k = 64'ha4506cebde82bde9;
            7'd62: round_k = 64'hbef9a3f7b2c67915; 7'd63: round_k = 64'hc67178f2e372532b;
            7'd64: round_k = 64'hca273eceea26619c; 7'd65: round_k = 64'hd186b8c721c0c207;
            7'd66: round_k = 64'heada7dd6cde0eb1e; 7'd67: round_k = 64'hf57d4f7fee6ed178;
            7'd68: round_k = 64'h06f067aa72176fba; 7'd69: round_k = 64'h0a637dc5a2c898a6;
            7'd70: round_k = 64'h113f9804bef90dae; 7'd71: round_k = 64'h1b710b35131c471b;
            7'd72: round_k = 64'h28db77f523047d84; 7'd73: round_k = 64'h32caab7b40c72493;
            7'd74: round_k = 64'h3c9ebe0a15c9bebc; 7'd75: round_k = 64'h431d67c49c100d4c;
            7'd76: round_k = 64'h4cc5d4becb3e42b6; 7'd77: round_k = 64'h597f299cfc657e2a;
            7'd78: round_k = 64'h5fcb6fab3ad6faec; 7'd79: round_k = 64'h6c44198c4a475817;
            default: round_k = '0;
        endcase
    endfunction

endpackage

/* src/sha512_sched.sv */
// Message schedule held in a 16-entry shift window, shifted once per round.
module sha512_sched
(
    input  logic                clk,
    input  logic                wr_en,      // external word write
    input  logic [3:0]          wr_addr,
    input  sha512_pkg::word_t   wr_data,
    input  logic                rnd_en,     // a round consumes w[t]
    input  logic [6:0]          rnd_t,
    output sha512_pkg::word_t   w_out
);
    // Four read ports realized as register copies of the same write stream
    // would be one option; here the window lives in a 16-deep shift line,
    // which each round reads at fixed taps.
    sha512_pkg::word_t win_reg [16];
    sha512_pkg::word_t new_w;

    assign new_w = win_reg[0] + sha512_pkg::sig0(win_reg[1]) + win_reg[9]
                 + sha512_pkg::sig1(win_reg[14]);
    assign w_out = win_reg[0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            win_reg[wr_addr] <= wr_data;
        end
        else if (rnd_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[15] <= (rnd_t < 7'd64) ? new_w : win_reg[0];
        end
    end
endmodule

/* src/sha512_round.sv */
// Compression round datapath and chaining memory.
module sha512_round
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sha512_pkg::rnd_ctrl_t ctrl,
    input  logic [6:0]            rnd_t,
    input  sha512_pkg::word_t     w_in,
    input  logic [2:0]            rd_addr,
    output sha512_pkg::word_t     rd_data
);
    sha512_pkg::word_t h_reg [8];
    sha512_pkg::word_t v_reg [8];
    sha512_pkg::word_t t1, t2;

    assign t1 = v_reg[7] + sha512_pkg::bsig1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sha512_pkg::round_k(rnd_t) + w_in;
    assign t2 = sha512_pkg::bsig0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    assign rd_data = h_reg[rd_addr];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg[0] <= sha512_pkg::INIT_H0; h_reg[1] <= sha512_pkg::INIT_H1;
            h_reg[2] <= sha512_pkg::INIT_H2; h_reg[3] <= sha512_pkg::INIT_H3;
            h_reg[4] <= sha512_pkg::INIT_H4; h_reg[5] <= sha512_pkg::INIT_H5;
            h_reg[6] <= sha512_pkg::INIT_H6; h_reg[7] <= sha512_pkg::INIT_H7;
        end
        else if (ctrl.reinit)
        begin
            h_reg[0] <= sha512_pkg::INIT_H0; h_reg[1] <= sha512_pkg::INIT_H1;
            h_reg[2] <= sha512_pkg::INIT_H2; h_reg[3] <= sha512_pkg::INIT_H3;
            h_reg[4] <= sha512_pkg::INIT_H4; h_reg[5] <= sha512_pkg::INIT_H5;
            h_reg[6] <= sha512_pkg::INIT_H6; h_reg[7] <= sha512_pkg::INIT_H7;
        end
        else if (ctrl.fold)
        begin
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= h_reg[i] + v_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        else if (ctrl.round_en)
        begin
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end
endmodule

/* src/sha512_hash_engine.sv */
// Top level of the SHA-512 engine: input sequencer, padding and digest output.
// Usage:
//   Input channel (in_valid/in_stall): message_word, valid_bytes, final_word.
//   Words are big-endian; valid_bytes only matters on the final word.
//   Output channel (out_valid/out_stall): digest_word, digest_index,
//   digest_done; eight items per message, index 0 to 7, done on index 7.
// Timing:
//   A non-closing word is written into the schedule window; the word that
//   fills a 128-byte block is followed by load, 80 rounds and fold, run by
//   the single round unit doing one round per cycle. The final word adds
//   padding (fill words over one or both blocks, then the two length
//   words), one or two compressions and eight output items.
//   Output items leave from one output register; a stall holds it and the
//   engine waits. Input is stalled whenever the engine is not idle.
// Reset: asynchronous, active low; chaining words return to the initial
// hash, byte total and fill position to zero, the output is emptied.
module sha512_hash_engine
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] message_word,
    input  logic [3:0]  valid_bytes,
    input  logic        final_word,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] digest_word,
    output logic [2:0]  digest_index,
    output logic        digest_done
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_FILL  = 7'b0000010,  // zero-fill up to word 13 or 15
        ST_LEN   = 7'b0000100,  // write length words 14 and 15
        ST_LOAD  = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_FOLD  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t      state_reg, state_next;
    logic [63:0] total_reg;
    logic [3:0]  fill_reg;
    logic [6:0]  t_reg;
    logic        fin_reg;     // padding in progress
    logic        pad_reg;     // pad byte still to be written
    logic        last_reg;    // this compression finishes the message
    logic [3:0]  ocnt_reg;    // output words sent
    logic        ov_reg;
    logic [63:0] ow_reg;
    logic [2:0]  oi_reg;

    logic                  acc;
    logic                  wr_en;
    logic [3:0]            wr_addr;
    sha512_pkg::word_t     wr_data;
    sha512_pkg::word_t     w_cur, h_rd;
    sha512_pkg::rnd_ctrl_t ctrl;
    logic [3:0]            vb;
    logic [63:0]           mask, padded, tot_new;
    logic                  emit;

    assign acc = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign vb = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
    assign tot_new = total_reg + (final_word ? {60'd0, vb} : 64'd8);

    always_comb
    begin
        mask = '1;
        padded = {sha512_pkg::PAD_BYTE, 56'd0};
        if (vb < 4'd8)
        begin
            mask = ~(64'hffff_ffff_ffff_ffff >> {vb[2:0], 3'b000});
            padded = (message_word & mask)
                   | ({56'd0, sha512_pkg::PAD_BYTE} << (7'd56 - {vb[2:0], 3'b000}));
        end
    end

    // Output handoff: load a new word when the register is free or drained.
    assign emit = (state_reg == ST_OUT) && (!ov_reg || !out_stall) && (ocnt_reg < 4'd8);

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = fill_reg;
        wr_data = message_word;
        ctrl = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (acc)
                begin
                    wr_en = 1'b1;
                    if (final_word && vb < 4'd8)
                    begin
                        wr_data = padded;
                    end
                    if (fill_reg == 4'd15)
                    begin
                        state_next = ST_LOAD;
                    end
                    else if (final_word)
                    begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL:
            begin
                wr_en = 1'b1;
                wr_data = pad_reg ? {sha512_pkg::PAD_BYTE, 56'd0} : '0;
                if (!pad_reg && last_reg && fill_reg == 4'd14)
                begin
                    wr_en = 1'b0;
                    state_next = ST_LEN;
                end
                else if (fill_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LEN:
            begin
                wr_en = 1'b1;
                wr_data = (fill_reg == 4'd14) ? {61'd0, total_reg[63:61]}
                                              : {total_reg[60:0], 3'b000};
                if (fill_reg == 4'd15)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ctrl.load = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctrl.round_en = 1'b1;
                if (t_reg == 7'd79)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                ctrl.fold = 1'b1;
                if (last_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (fin_reg)
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (ocnt_reg == 4'd8)
                begin
                    ctrl.reinit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    sha512_sched u_sched
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rnd_en  (ctrl.round_en),
        .rnd_t   (t_reg),
        .w_out   (w_cur)
    );

    sha512_round u_round
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rnd_t   (t_reg),
        .w_in    (w_cur),
        .rd_addr (ocnt_reg[2:0]),
        .rd_data (h_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            fill_reg  <= '0;
            t_reg     <= '0;
            fin_reg   <= 1'b0;
            pad_reg   <= 1'b0;
            last_reg  <= 1'b0;
            ocnt_reg  <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en || state_reg == ST_LEN)
            begin
                fill_reg <= fill_reg + 4'd1;
            end
            if (state_reg == ST_LOAD)
            begin
                t_reg <= '0;
            end
            else if (state_reg == ST_ROUND)
            begin
                t_reg <= t_reg + 7'd1;
            end
            if (acc)
            begin
                total_reg <= tot_new;
                fin_reg <= final_word;
                // A full final word leaves the pad byte for the next slot.
                pad_reg <= final_word && vb == 4'd8;
                last_reg <= final_word && ((vb < 4'd8) ? (fill_reg < 4'd14)
                                                       : (fill_reg < 4'd13));
            end
            if (state_reg == ST_FILL)
            begin
                pad_reg <= 1'b0;
            end
            if (state_reg == ST_FOLD && fin_reg && !last_reg)
            begin
                // Second pass of the final sequence.
                last_reg <= 1'b1;
            end
            if (state_reg == ST_OUT && ocnt_reg == 4'd8)
            begin
                total_reg <= '0;
                fill_reg  <= '0;
                fin_reg   <= 1'b0;
                last_reg  <= 1'b0;
                ocnt_reg  <= '0;
            end
            else if (emit)
            begin
                ocnt_reg <= ocnt_reg + 4'd1;
            end
            if (emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Pending pad byte for a full final word is written by the fill pass.
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            ow_reg <= h_rd;
            oi_reg <= ocnt_reg[2:0];
        end
    end

    assign out_valid    = ov_reg;
    assign digest_word  = ow_reg;
    assign digest_index = oi_reg;
    assign digest_done  = (oi_reg == 3'd7);

`ifndef SYNTHESIS
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !acc)
        else $error("item accepted while busy");
    a_rounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> ($past(t_reg) == 7'd79))
        else $error("fold before 80 rounds");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(ow_reg)))
        else $error("output changed under stall");
`endif
endmodule
